FILE: src/llgm_pkg.sv
// Package: widths, fixed-point helpers and shared command/status types for the LLG midpoint step.
`timescale 1ns / 1ps
`default_nettype none
package llgm_pkg;
  localparam int WordWidth = 32;
  localparam int FracBits = 24;
  localparam int IterWidth = 10;
  localparam int TolWidth = 31;

  typedef logic signed [WordWidth-1:0] word_t;
  typedef logic [IterWidth-1:0] iter_t;

  localparam logic signed [WordWidth-1:0] WordMax = {1'b0, {(WordWidth-1){1'b1}}};
  localparam logic signed [WordWidth-1:0] WordMin = {1'b1, {(WordWidth-1){1'b0}}};
  localparam logic signed [WordWidth-1:0] One = word_t'(64'sd1 <<< FracBits);

  // Register indexes on the configuration port.
  localparam logic [2:0] RegHalfStep = 3'd0;
  localparam logic [2:0] RegDamping = 3'd1;
  localparam logic [2:0] RegPrecession = 3'd2;
  localparam logic [2:0] RegTolerance = 3'd3;
  localparam logic [2:0] RegIterLimit = 3'd4;

  // Datapath micro-operations, one per sequencer step.
  typedef enum logic [4:0] {
    OP_LOAD, OP_EXTRAP, OP_CRS_P, OP_CRS_D, OP_HT_FULL,
    OP_A, OP_CMH_P, OP_CMH_D, OP_R, OP_AR, OP_AA, OP_CAR_P, OP_CAR_D,
    OP_NUM, OP_DIV_START, OP_DIV_STEP, OP_DIV_END, OP_MID, OP_CRS2_P, OP_CRS2_D,
    OP_HT_ITER, OP_ERR, OP_NOP
  } op_t;

  typedef struct packed {
    op_t  op;
    logic [1:0] lane;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic conv;
  } dp_stat_t;

  // Saturate a wide value to the word range.
  function automatic word_t sat(input logic signed [2*WordWidth+3:0] v);
    if (v > $signed({{(WordWidth+4){1'b0}}, WordMax})) return WordMax;
    if (v < $signed({{(WordWidth+4){1'b1}}, WordMin})) return WordMin;
    return v[WordWidth-1:0];
  endfunction

  // Rounded Q product, ties toward +inf, saturated.
  function automatic word_t fmul(input word_t a, input word_t b);
    logic signed [2*WordWidth+3:0] p;
    p = (2*WordWidth+4)'(a) * (2*WordWidth+4)'(b);
    p = p + (2*WordWidth+4)'(64'sd1 <<< (FracBits-1));
    return sat(p >>> FracBits);
  endfunction
endpackage
`default_nettype wire

FILE: src/llgm_datapath.sv
// Datapath: vector registers, per-operation multipliers and a radix-2 divider.
`timescale 1ns / 1ps
`default_nettype none
module llgm_datapath
  import llgm_pkg::*;
(
  input  wire logic clk,
  input  wire dp_cmd_t cmd,
  input  wire word_t in_vec [12],
  input  wire word_t half_step,
  input  wire word_t damping,
  input  wire logic precession_on,
  input  wire logic [TolWidth-1:0] tolerance,
  output dp_stat_t stat,
  output word_t m2_out [3]
);
  localparam int WW = 2*WordWidth+4;
  typedef logic signed [WW-1:0] wide_t;

  word_t m [3], mp [3], h [3], hp [3], m12 [3], h12 [3], ht [3];
  word_t a [3], r [3], c [3], pa [3], pb [3], m2 [3], prev [3], n [3];
  word_t ar, den;
  logic conv;
  // divider state
  logic [WordWidth+FracBits:0] rem;
  logic [WordWidth+FracBits-1:0] dividend;
  logic [WordWidth+FracBits-1:0] quo;
  logic [6:0] dcnt;
  logic neg;

  function automatic word_t ext(input word_t x, input word_t y);
    wide_t t;
    t = 3*wide_t'(x) - wide_t'(y) + 1;
    return sat(t >>> 1);
  endfunction

  function automatic word_t mid2(input word_t x, input word_t y);
    wide_t t;
    t = wide_t'(x) + wide_t'(y) + 1;
    return sat(t >>> 1);
  endfunction

  function automatic logic [WordWidth:0] absd(input word_t x, input word_t y);
    wide_t d;
    d = wide_t'(x) - wide_t'(y);
    if (d < 0) d = -d;
    return d[WordWidth:0];
  endfunction

  wire logic [1:0] i = cmd.lane;
  wire logic [1:0] j = (i == 2'd2) ? 2'd0 : i + 2'd1;
  wire logic [1:0] k = (j == 2'd2) ? 2'd0 : j + 2'd1;

  // Error norm check on the new M2 against the previous guess
  logic [WordWidth:0] ad [3];
  logic [2*WordWidth+2:0] e2;
  logic big;
  always_comb begin
    e2 = '0;
    big = 1'b0;
    for (int q = 0; q < 3; q++) begin
      ad[q] = absd(m2[q], prev[q]);
      if (ad[q] > (WordWidth+1)'(tolerance)) big = 1'b1;
      else e2 = e2 + (2*WordWidth+3)'(ad[q]) * (2*WordWidth+3)'(ad[q]);
    end
  end
  wire logic [2*WordWidth+2:0] tol2 = (2*WordWidth+3)'(tolerance) *
                                      (2*WordWidth+3)'(tolerance);

  // Restoring divide step
  wire logic [WordWidth+FracBits:0] rsh = {rem[WordWidth+FracBits-1:0],
                                           dividend[WordWidth+FracBits-1]};
  wire logic [WordWidth+FracBits:0] dext = (WordWidth+FracBits+1)'(unsigned'(den));
  wire logic [WordWidth+FracBits:0] q_full = (WordWidth+FracBits+1)'(quo) + 1'b1;
  wire logic round_up = ({rem, 1'b0} >= {1'b0, dext});

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        for (int q = 0; q < 3; q++) begin
          m[q] <= in_vec[q]; mp[q] <= in_vec[3+q];
          h[q] <= in_vec[6+q]; hp[q] <= in_vec[9+q];
        end
        conv <= 1'b0;
      end
      OP_EXTRAP: begin
        for (int q = 0; q < 3; q++) begin
          m12[q] <= ext(m[q], mp[q]); h12[q] <= ext(h[q], hp[q]);
          prev[q] <= m[q]; m2[q] <= '0;
        end
      end
      OP_CRS_P, OP_CRS2_P: begin
        pa[i] <= fmul(m12[j], h12[k]); pb[i] <= fmul(m12[k], h12[j]);
      end
      OP_CMH_P: begin
        pa[i] <= fmul(m[j], ht[k]); pb[i] <= fmul(m[k], ht[j]);
      end
      OP_CAR_P: begin
        pa[i] <= fmul(a[j], r[k]); pb[i] <= fmul(a[k], r[j]);
      end
      OP_CRS_D, OP_CMH_D, OP_CAR_D, OP_CRS2_D:
        c[i] <= sat(wide_t'(pa[i]) - wide_t'(pb[i]));
      OP_HT_FULL: ht[i] <= sat(wide_t'(fmul(damping, c[i])) + wide_t'(h12[i]));
      OP_HT_ITER: ht[i] <= precession_on ?
                  sat(wide_t'(fmul(damping, c[i])) + wide_t'(h12[i])) : fmul(damping, c[i]);
      OP_A: a[i] <= fmul(half_step, ht[i]);
      OP_R: r[i] <= sat(wide_t'(m[i]) - wide_t'(fmul(half_step, c[i])));
      OP_AR: ar <= sat(wide_t'(fmul(a[0], r[0])) + wide_t'(fmul(a[1], r[1]))
                       + wide_t'(fmul(a[2], r[2])));
      OP_AA: den <= sat(wide_t'(One) + wide_t'(sat(wide_t'(fmul(a[0], a[0]))
                       + wide_t'(fmul(a[1], a[1])) + wide_t'(fmul(a[2], a[2])))));
      OP_NUM: n[i] <= sat(wide_t'(r[i]) + wide_t'(fmul(ar, a[i])) + wide_t'(c[i]));
      OP_DIV_START: begin
        neg <= n[i][WordWidth-1];
        dividend <= {(n[i][WordWidth-1] ? WordWidth'(-n[i]) : WordWidth'(n[i])),
                     {FracBits{1'b0}}};
        rem <= '0; quo <= '0; dcnt <= '0;
      end
      OP_DIV_STEP: begin
        dividend <= dividend << 1;
        dcnt <= dcnt + 7'd1;
        if (rsh >= dext) begin
          rem <= rsh - dext; quo <= {quo[WordWidth+FracBits-2:0], 1'b1};
        end else begin
          rem <= rsh; quo <= {quo[WordWidth+FracBits-2:0], 1'b0};
        end
      end
      OP_DIV_END: begin
        m2[i] <= neg ? sat(-wide_t'(round_up ? q_full : {1'b0, quo}))
                     : sat(wide_t'(round_up ? q_full : {1'b0, quo}));
      end
      OP_MID: m12[i] <= mid2(m[i], m2[i]);
      OP_ERR: begin
        conv <= !big && (e2 <= tol2);
        for (int q = 0; q < 3; q++) prev[q] <= m2[q];
      end
      default: ;
    endcase
  end

  assign stat.div_done = (dcnt == 7'(WordWidth+FracBits));
  assign stat.conv = conv;
  assign m2_out = m2;
endmodule
`default_nettype wire

FILE: src/llgm_ctrl.sv
// Controller: sequencer that walks the datapath through setup and each iteration.
`timescale 1ns / 1ps
`default_nettype none
module llgm_ctrl
  import llgm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire iter_t iteration_limit,
  input  wire dp_stat_t stat,
  output dp_cmd_t cmd,
  output logic busy,
  output logic done,
  output iter_t iter_count
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_RUN = 6'b000010, S_DIV = 6'b000100,
    S_CHECK = 6'b001000, S_DONE = 6'b010000, S_SETUP = 6'b100000
  } state_t;

  // Micro-program of one iteration (lane-indexed where marked)
  localparam int Steps = 17;
  typedef struct packed { op_t op; logic lanes; } uop_t;
  function automatic uop_t prog(input logic [4:0] p);
    case (p)
      5'd0: return '{OP_A, 1'b1};
      5'd1: return '{OP_CMH_P, 1'b1};
      5'd2: return '{OP_CMH_D, 1'b1};
      5'd3: return '{OP_R, 1'b1};
      5'd4: return '{OP_AR, 1'b0};
      5'd5: return '{OP_AA, 1'b0};
      5'd6: return '{OP_CAR_P, 1'b1};
      5'd7: return '{OP_CAR_D, 1'b1};
      5'd8: return '{OP_NUM, 1'b1};
      5'd9: return '{OP_DIV_START, 1'b1};
      5'd10: return '{OP_DIV_END, 1'b1};
      5'd11: return '{OP_MID, 1'b1};
      5'd12: return '{OP_CRS2_P, 1'b1};
      5'd13: return '{OP_CRS2_D, 1'b1};
      5'd14: return '{OP_HT_ITER, 1'b1};
      5'd15: return '{OP_ERR, 1'b0};
      default: return '{OP_NOP, 1'b0};
    endcase
  endfunction
  function automatic op_t setup_op(input logic [2:0] p);
    case (p)
      3'd0: return OP_EXTRAP;
      3'd1: return OP_CRS_P;
      3'd2: return OP_CRS_D;
      3'd3: return OP_HT_FULL;
      default: return OP_NOP;
    endcase
  endfunction

  state_t state, state_next;
  logic [4:0] pc;
  logic [2:0] spc;
  logic [1:0] lane;
  iter_t limit;
  uop_t u;
  assign u = prog(pc);

  always_comb begin
    state_next = state;
    cmd = '{OP_NOP, lane};
    case (state)
      // Operands are captured at the accepting edge
      S_IDLE: if (start) begin
        cmd.op = OP_LOAD;
        state_next = S_SETUP;
      end
      S_SETUP: begin
        cmd.op = setup_op(spc);
        if (spc == 3'd3 && lane == 2'd2) state_next = S_RUN;
      end
      S_RUN: begin
        cmd.op = u.op;
        if (u.op == OP_DIV_START) state_next = S_DIV;
        if (pc == 5'(Steps - 2)) state_next = S_CHECK;
      end
      S_DIV: begin
        cmd.op = OP_DIV_STEP;
        if (stat.div_done) begin
          cmd.op = OP_DIV_END; state_next = S_RUN;
        end
      end
      S_CHECK:
        if (stat.conv || iter_count >= limit) state_next = S_DONE;
        else state_next = S_RUN;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Steps with lanes repeat over x, y, z before moving on.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; pc <= '0; spc <= '0; lane <= '0; iter_count <= '0; limit <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: if (start) begin
          limit <= (iteration_limit == '0) ? iter_t'(1) : iteration_limit;
          iter_count <= '0; spc <= '0; lane <= '0;
        end
        S_SETUP:
          if (spc == 3'd0 || lane == 2'd2) begin
            lane <= '0; spc <= spc + 3'd1;
            if (spc == 3'd3) begin pc <= '0; iter_count <= iter_count + iter_t'(1); end
          end else lane <= lane + 2'd1;
        S_RUN: begin
          if (pc == 5'd0 && lane == 2'd0 && iter_count == '0)
            iter_count <= iter_count + iter_t'(1);
          if (u.op == OP_DIV_START) ;
          else if (!u.lanes || lane == 2'd2) begin lane <= '0; pc <= pc + 5'd1; end
          else lane <= lane + 2'd1;
        end
        S_DIV: if (stat.div_done) begin
          pc <= 5'd9;
          if (lane == 2'd2) begin lane <= '0; pc <= 5'd11; end
          else lane <= lane + 2'd1;
        end
        S_CHECK: begin
          pc <= '0; lane <= '0;
          if (!(stat.conv || iter_count >= limit)) iter_count <= iter_count + iter_t'(1);
        end
        default: ;
      endcase
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);
endmodule
`default_nettype wire

FILE: src/llg_midpoint_step.sv
// Top level: LLG implicit-midpoint update for one mesh node.
// Each transaction runs the setup lane steps once and then, per iteration, the
// micro-program lane steps, a check state and three bit-serial divisions
// (a 56-bit quotient each, plus start and end steps). start is taken when
// busy is low and the operands are captured at that edge; the result appears
// on next_mag_* with done high for one cycle and must be captured then.
`timescale 1ns / 1ps
`default_nettype none
module llg_midpoint_step
  import llgm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic busy,
  input  wire word_t mag_x, input wire word_t mag_y, input wire word_t mag_z,
  input  wire word_t prev_mag_x, input wire word_t prev_mag_y, input wire word_t prev_mag_z,
  input  wire word_t field_x, input wire word_t field_y, input wire word_t field_z,
  input  wire word_t prev_field_x, input wire word_t prev_field_y,
  input  wire word_t prev_field_z,
  input  wire logic cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [WordWidth-1:0] cfg_data,
  output logic done,
  output word_t next_mag_x, output word_t next_mag_y, output word_t next_mag_z,
  output iter_t iterations_used,
  output logic converged
);
  word_t half_step, damping;
  logic precession_on;
  logic [TolWidth-1:0] tolerance;
  iter_t iteration_limit;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      half_step <= '0; damping <= '0; precession_on <= 1'b1;
      tolerance <= TolWidth'(17); iteration_limit <= iter_t'(1000);
    end else if (cfg_we) begin
      case (cfg_index)
        RegHalfStep: half_step <= cfg_data;
        RegDamping: damping <= cfg_data;
        RegPrecession: precession_on <= cfg_data[0];
        RegTolerance: tolerance <= cfg_data[TolWidth-1:0];
        RegIterLimit: iteration_limit <= cfg_data[IterWidth-1:0];
        default: ;
      endcase
    end
  end

  word_t in_vec [12];
  assign in_vec = '{mag_x, mag_y, mag_z, prev_mag_x, prev_mag_y, prev_mag_z,
                    field_x, field_y, field_z, prev_field_x, prev_field_y, prev_field_z};

  dp_cmd_t cmd;
  dp_stat_t stat;
  word_t m2 [3];

  llgm_ctrl u_ctrl (.clk, .rst, .start, .iteration_limit, .stat, .cmd, .busy, .done,
                    .iter_count(iterations_used));
  llgm_datapath u_dp (.clk, .cmd, .in_vec, .half_step, .damping, .precession_on,
                      .tolerance, .stat, .m2_out(m2));

  assign next_mag_x = m2[0];
  assign next_mag_y = m2[1];
  assign next_mag_z = m2[2];
  assign converged = stat.conv;
endmodule
`default_nettype wire

FILE: src/llgm_checker.sv
// Port-level checker for the LLG midpoint step, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module llgm_checker
  import llgm_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done,
  input wire iter_t iterations_used
);
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done longer than one cycle");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("start not taken");
  a_iter_nonzero: assert property (@(posedge clk) disable iff (rst)
    done |-> (iterations_used != '0)) else $error("zero iterations reported");
endmodule

bind llg_midpoint_step llgm_checker u_chk (.clk, .rst, .start, .busy, .done,
                                           .iterations_used);
`default_nettype wire

FILE: tb/llg_midpoint_step_tb.sv
// Testbench for llg_midpoint_step: directed table, then randomized nodes checked by a predictor.
`timescale 1ns / 1ps
module llg_midpoint_step_tb;
  import llgm_pkg::*;

  localparam int HalfPeriod = 4;
  localparam int StallLimit = 1000000;
  localparam int RandomItems = 1800;
  localparam int RandomPhases = 12;

  typedef struct {
    word_t v[12];
  } node_t;

  typedef struct {
    word_t x, y, z;
    iter_t iters;
    logic conv;
  } step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done, converged;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = RegHalfStep;
  logic [WordWidth-1:0] cfg_data = '0;
  word_t next_mag_x, next_mag_y, next_mag_z;
  iter_t iterations_used;
  node_t cur;

  // Local copy of the register file
  longint hs_q = 0, damp_q = 0;
  bit prec_q = 1'b1;
  longint unsigned tol_q = 17;
  int unsigned lim_q = 1000;

  step_t pending_steps[$];
  int errors = 0, accepted = 0, completed = 0, unconverged = 0, idle_pct = 0;
  int stall_cycles = 0;

  // Directed table
  node_t dir_in[$];
  bit dir_typed[$];
  step_t dir_exp[$];

  always #HalfPeriod clk = ~clk;

  llg_midpoint_step u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .mag_x(cur.v[0]), .mag_y(cur.v[1]), .mag_z(cur.v[2]),
    .prev_mag_x(cur.v[3]), .prev_mag_y(cur.v[4]), .prev_mag_z(cur.v[5]),
    .field_x(cur.v[6]), .field_y(cur.v[7]), .field_z(cur.v[8]),
    .prev_field_x(cur.v[9]), .prev_field_y(cur.v[10]), .prev_field_z(cur.v[11]),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .next_mag_x(next_mag_x), .next_mag_y(next_mag_y),
    .next_mag_z(next_mag_z), .iterations_used(iterations_used), .converged(converged)
  );

  // ---------------- fixed-point predictor ----------------
  function automatic longint clamp(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return clamp((a * b + (64'sd1 <<< (FracBits - 1))) >>> FracBits);
  endfunction

  // den is always positive here
  function automatic longint qdiv(longint n, longint den);
    longint unsigned mag, q;
    mag = (n < 0) ? longint'(-n) : n;
    q = ((mag << FracBits) + longint'(den) / 2) / longint'(den);
    return clamp((n < 0) ? -longint'(q) : longint'(q));
  endfunction

  function automatic longint extrap(longint x, longint y);
    return clamp((3 * x - y + 1) >>> 1);
  endfunction

  function automatic longint midq(longint x, longint y);
    return clamp((x + y + 1) >>> 1);
  endfunction

  function automatic longint dotq(longint a[3], longint b[3]);
    return clamp(qmul(a[0], b[0]) + qmul(a[1], b[1]) + qmul(a[2], b[2]));
  endfunction

  task automatic crossq(input longint a[3], input longint b[3], output longint o[3]);
    o[0] = clamp(qmul(a[1], b[2]) - qmul(a[2], b[1]));
    o[1] = clamp(qmul(a[2], b[0]) - qmul(a[0], b[2]));
    o[2] = clamp(qmul(a[0], b[1]) - qmul(a[1], b[0]));
  endtask

  // Effective field: damping * (m x h), plus h when the field term is on
  task automatic eff_field(input longint m[3], input longint h[3], input bit with_h,
                           output longint ht[3]);
    longint c[3];
    crossq(m, h, c);
    for (int i = 0; i < 3; i++) begin
      ht[i] = qmul(damp_q, c[i]);
      if (with_h) ht[i] = clamp(ht[i] + h[i]);
    end
  endtask

  task automatic predict_step(input node_t nd, output step_t res);
    longint m[3], m12[3], h12[3], ht[3], m2[3], last[3], a[3], r[3], c[3], nm[3];
    longint ar, den, dlt;
    longint unsigned e2, ad, tol2;
    int unsigned lim, it;
    bit conv, big;
    tol2 = tol_q * tol_q;
    lim = (lim_q == 0) ? 1 : lim_q;
    it = 0;
    conv = 1'b0;
    for (int i = 0; i < 3; i++) begin
      m[i] = nd.v[i];
      m12[i] = extrap(nd.v[i], nd.v[3+i]);
      h12[i] = extrap(nd.v[6+i], nd.v[9+i]);
      last[i] = m[i];
      m2[i] = 0;
    end
    // first guess always carries the field term
    eff_field(m12, h12, 1'b1, ht);
    while (!conv && it < lim) begin
      it++;
      e2 = 0;
      big = 1'b0;
      for (int i = 0; i < 3; i++) a[i] = qmul(hs_q, ht[i]);
      crossq(m, ht, c);
      for (int i = 0; i < 3; i++) r[i] = clamp(m[i] - qmul(hs_q, c[i]));
      ar = dotq(a, r);
      den = clamp((64'sd1 <<< FracBits) + dotq(a, a));
      crossq(a, r, c);
      for (int i = 0; i < 3; i++) begin
        nm[i] = clamp(r[i] + qmul(ar, a[i]) + c[i]);
        m2[i] = qdiv(nm[i], den);
        m12[i] = midq(m[i], m2[i]);
      end
      eff_field(m12, h12, prec_q, ht);
      for (int i = 0; i < 3; i++) begin
        dlt = m2[i] - last[i];
        ad = (dlt < 0) ? longint'(-dlt) : dlt;
        if (ad > tol_q) big = 1'b1;
        else e2 += ad * ad;
        last[i] = m2[i];
      end
      conv = !big && (e2 <= tol2);
    end
    res.x = word_t'(m2[0]);
    res.y = word_t'(m2[1]);
    res.z = word_t'(m2[2]);
    res.iters = iter_t'(it);
    res.conv = conv;
  endtask

  // ---------------- result checker and watchdog ----------------
  always @(posedge clk) begin
    step_t e;
    if (!rst) begin
      if (done) begin
        stall_cycles <= 0;
        completed++;
        if (!converged) unconverged++;
        if (pending_steps.size() == 0) begin
          $display("%0t: unexpected result x=%h y=%h z=%h", $time,
                   next_mag_x, next_mag_y, next_mag_z);
          errors++;
        end else begin
          e = pending_steps.pop_front();
          if (next_mag_x !== e.x || next_mag_y !== e.y || next_mag_z !== e.z) begin
            $display("%0t: next_mag mismatch exp=(%h %h %h) act=(%h %h %h)", $time,
                     e.x, e.y, e.z, next_mag_x, next_mag_y, next_mag_z);
            errors++;
          end
          if (iterations_used !== e.iters) begin
            $display("%0t: iterations_used mismatch exp=%0d act=%0d", $time,
                     e.iters, iterations_used);
            errors++;
          end
          if (converged !== e.conv) begin
            $display("%0t: converged mismatch exp=%0b act=%0b", $time, e.conv, converged);
            errors++;
          end
        end
      end else if (start && !busy) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time,
                 pending_steps.size());
        $display("Regression FAIL");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // ---------------- stimulus helpers ----------------
  // Present one node; returns once the block has taken it
  task automatic send_node(input node_t nd, input bit typed, input step_t typed_exp);
    step_t p;
    while ($urandom_range(0, 99) < idle_pct) @(negedge clk);
    cur = nd;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (typed) p = typed_exp;
    else predict_step(nd, p);
    pending_steps.push_back(p);
    accepted++;
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic drain;
    while (pending_steps.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [WordWidth-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    case (idx)
      RegHalfStep: hs_q = longint'($signed(val));
      RegDamping: damp_q = longint'($signed(val));
      RegPrecession: prec_q = val[0];
      RegTolerance: tol_q = val[TolWidth-1:0];
      RegIterLimit: lim_q = val[IterWidth-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_regs(input logic [31:0] hs, input logic [31:0] dmp, input bit prec,
                           input logic [31:0] tol, input logic [31:0] lim);
    drain();
    write_reg(RegHalfStep, hs);
    write_reg(RegDamping, dmp);
    write_reg(RegPrecession, {31'b0, prec});
    write_reg(RegTolerance, tol);
    write_reg(RegIterLimit, lim);
  endtask

  function automatic node_t rand_node(bit wide);
    node_t nd;
    for (int i = 0; i < 12; i++)
      nd.v[i] = wide ? word_t'($urandom) : word_t'($signed($urandom_range(0, 67108863)) - 33554432);
    return nd;
  endfunction

  function automatic node_t fill_node(word_t m, word_t mp, word_t h, word_t hp);
    node_t nd;
    for (int i = 0; i < 3; i++) begin
      nd.v[i] = m;
      nd.v[3+i] = mp;
      nd.v[6+i] = h;
      nd.v[9+i] = hp;
    end
    return nd;
  endfunction

  task automatic add_row(input node_t nd, input bit typed);
    step_t e;
    e.x = nd.v[0];
    e.y = nd.v[1];
    e.z = nd.v[2];
    e.iters = iter_t'(1);
    e.conv = 1'b1;
    dir_in.push_back(nd);
    dir_typed.push_back(typed);
    dir_exp.push_back(e);
  endtask

  task automatic run_rows(input int first, input int last);
    for (int k = first; k <= last; k++) send_node(dir_in[k], dir_typed[k], dir_exp[k]);
  endtask

  // ---------------- main sequence ----------------
  initial begin
    node_t nd;
    step_t none;
    logic [31:0] hs, dmp, tol, lim;
    int per_phase;
    for (int i = 0; i < 12; i++) cur.v[i] = '0;

    // Zero half step at reset: each node comes back unchanged after one pass
    add_row(fill_node('0, '0, '0, '0), 1'b1);
    add_row(fill_node(WordMax, WordMax, WordMax, WordMax), 1'b1);
    add_row(fill_node(WordMin, WordMin, WordMin, WordMin), 1'b1);
    add_row(fill_node(WordMax, WordMin, WordMin, WordMax), 1'b1);
    add_row(fill_node(One, -One, One, 32'sd0), 1'b1);
    add_row(fill_node(32'sd1, -32'sd1, 32'sd1, -32'sd1), 1'b1);
    add_row(fill_node(WordMin, WordMax, WordMax, WordMin), 1'b1);
    // Small step with damping: predictor rows
    add_row(fill_node(One, One, One, One), 1'b0);
    add_row(fill_node(-One, 32'sd0, One >>> 1, One), 1'b0);
    nd = fill_node(One, One, 32'sd0, 32'sd0);
    nd.v[1] = 32'sd0; nd.v[2] = 32'sd0; nd.v[8] = One; nd.v[11] = One;
    add_row(nd, 1'b0);
    add_row(fill_node(32'sd12345678, -32'sd2000000, 32'sd3000000, 32'sd9000000), 1'b0);
    // Saturating rows: extreme step and damping
    add_row(fill_node(WordMax, WordMin, WordMax, WordMin), 1'b0);
    add_row(fill_node(WordMin, WordMax, One, -One), 1'b0);
    add_row(fill_node(One, -One, WordMax, WordMax), 1'b0);
    add_row(fill_node(-32'sd1, 32'sd1, WordMin, WordMax), 1'b0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_rows(0, 6);
    load_regs(32'sd167772, 32'sd1677722, 1'b1, 32'd17, 32'd1023);
    run_rows(7, 10);
    // zero limit runs one pass; zero tolerance converges only on an exact repeat
    load_regs(32'sd8388608, -32'sd4194304, 1'b0, 32'd0, 32'd0);
    run_rows(7, 10);
    load_regs(WordMax, WordMax, 1'b0, 32'h7fff_ffff, 32'd2);
    run_rows(11, 14);
    load_regs(WordMin, WordMin, 1'b1, 32'd0, 32'd3);
    run_rows(11, 14);

    // Random phases: light sender gaps, then heavy gaps, then back-to-back
    per_phase = RandomItems / RandomPhases;
    for (int ph = 0; ph < RandomPhases; ph++) begin
      idle_pct = (ph < RandomPhases / 3) ? 18 : (ph < 2 * RandomPhases / 3) ? 85 : 0;
      hs = ($urandom_range(0, 9) < 7) ? 32'($signed($urandom_range(0, 1677722)) - 838861)
                                      : $urandom;
      dmp = ($urandom_range(0, 1) != 0) ? 32'($signed($urandom_range(0, 3355444)) - 1677722)
                                        : $urandom;
      case ($urandom_range(0, 3))
        0: tol = 32'd0;
        1: tol = 32'd17;
        2: tol = $urandom_range(0, 1048575);
        default: tol = $urandom & 32'h7fff_ffff;
      endcase
      lim = $urandom_range(1, 4);
      if (ph == 4) begin
        hs = '0;
        lim = 32'd1023;
      end
      load_regs(hs, dmp, 1'($urandom_range(0, 1)), tol, lim);
      for (int k = 0; k < per_phase; k++)
        send_node(rand_node($urandom_range(0, 3) == 0), 1'b0, none);
    end

    idle_pct = 0;
    drain();
    repeat (300) @(negedge clk);
    $display("Ran %0d nodes (%0d results, %0d hit the iteration limit)", accepted,
             completed, unconverged);
    $display("Covered register extremes, zero limit, saturation and sender gap mixes");
    if (errors == 0 && pending_steps.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

FILE: llg_midpoint_step.f
src/llgm_pkg.sv
src/llgm_datapath.sv
src/llgm_ctrl.sv
src/llg_midpoint_step.sv
src/llgm_checker.sv
tb/llg_midpoint_step_tb.sv
